// File: hw/rtl/mmp_pkg.sv
// ----------------------------------------------------------------------------
// MPE MIDI message parser package
// Shared types, message kind codes and status constants.
// ----------------------------------------------------------------------------
package mmp_pkg;

    // Number of ports that a nonzero selector may name.
    localparam int PORT_COUNT = 16;

    localparam int BYTE_W    = 8;
    localparam int PORT_W    = 4;
    localparam int SEL_W     = 5;
    localparam int KIND_W    = 3;
    localparam int CHAN_W    = 4;
    localparam int DATA_W    = 7;
    localparam int BEND_W    = 14;
    localparam int TDATA_IN_W  = 8;
    localparam int TUSER_IN_W  = 4;
    localparam int TDATA_OUT_W = 40;
    localparam int TUSER_OUT_W = 3;

    // Status high nibbles that open a message.
    localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
    localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
    localparam logic [3:0] STATUS_CC       = 4'hB;
    localparam logic [3:0] STATUS_PRESSURE = 4'hD;
    localparam logic [3:0] STATUS_BEND     = 4'hE;

    localparam logic [DATA_W-1:0] SLIDE_CC = 7'd74;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOTE_ON  = 3'd0,
        KIND_NOTE_OFF = 3'd1,
        KIND_PRESSURE = 3'd2,
        KIND_SLIDE    = 3'd3,
        KIND_BEND     = 3'd4,
        KIND_NONE     = 3'd7
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] midi_byte;
        logic [PORT_W-1:0] port;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] channel;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] amount;
        logic [BEND_W-1:0] bend_value;
        logic [SEL_W-1:0]  port_number;
    } result_t;

    // Handshake between the decoder and its neighbor stages.
    typedef struct packed {
        logic in_valid;
        logic out_free;
    } dec_ctrl_t;

endpackage

// File: hw/rtl/mpe_midi_message_parser.sv
// ----------------------------------------------------------------------------
// MPE MIDI message parser
// Decodes MPE member-channel voice messages from a stream of tagged bytes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals               Contents (lowest bit first)
//  s_*      in         tvalid tready tdata   tdata: midi_byte[7:0]
//                      tuser                 tuser: port[3:0]
//  m_*      out        tvalid tready tdata   tdata: channel, key, amount,
//                      tuser                        bend_value, port_number
//                                            tuser: kind[2:0]
//  cfg_*    in         we wdata              port_select[4:0]
//
// One word is decoded per cycle unless a word that completes a message waits
// for the result register; m_tvalid is driven from the result register.
// The decode is a single combinational pass between the input register and
// the result register.
// A full result register stalls only words that complete a message.
// Reset clears the parser to idle and the port selector to zero.
// ----------------------------------------------------------------------------
module mpe_midi_message_parser
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mmp_pkg::TDATA_IN_W-1:0]       s_tdata,  // midi_byte[7:0]
    input  logic [mmp_pkg::TUSER_IN_W-1:0]       s_tuser,  // port[3:0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // channel[3:0], key[10:4], amount[17:11], bend_value[31:18],
    // port_number[36:32], zero[39:37]
    output logic [mmp_pkg::TDATA_OUT_W-1:0]      m_tdata,
    output logic [mmp_pkg::TUSER_OUT_W-1:0]      m_tuser,  // kind[2:0]
    input  logic                                 cfg_we,
    input  logic [mmp_pkg::SEL_W-1:0]            cfg_wdata
);

    mmp_pkg::in_item_t  s_item;
    mmp_pkg::in_item_t  item;
    logic               item_valid;
    logic               consume;
    logic               res_valid;
    mmp_pkg::result_t   res;
    logic               out_free;
    mmp_pkg::dec_ctrl_t ctrl;

    assign s_item.midi_byte = s_tdata;
    assign s_item.port      = s_tuser;

    assign ctrl.in_valid = item_valid;
    assign ctrl.out_free = out_free;

    mmp_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .consume    (consume),
        .item_valid (item_valid),
        .item       (item)
    );

    mmp_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctrl      (ctrl),
        .item      (item),
        .consume   (consume),
        .res_valid (res_valid),
        .res       (res)
    );

    mmp_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: hw/rtl/mmp_in_reg.sv
// ----------------------------------------------------------------------------
// MPE MIDI input register
// Holds one accepted word until the decoder consumes it.
// ----------------------------------------------------------------------------
module mmp_in_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mmp_pkg::in_item_t s_item,
    input  logic              consume,
    output logic              item_valid,
    output mmp_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    mmp_pkg::in_item_t item_reg;

    // The register frees up in the same cycle that its word is consumed.
    assign s_tready   = !valid_reg || consume;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hw/rtl/mmp_decode.sv
// ----------------------------------------------------------------------------
// MPE MIDI decoder
// Parser state, port filter and the single-pass decode of one byte.
// ----------------------------------------------------------------------------
module mmp_decode
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mmp_pkg::SEL_W-1:0]      cfg_wdata,
    input  mmp_pkg::dec_ctrl_t             ctrl,
    input  mmp_pkg::in_item_t              item,
    output logic                           consume,
    output logic                           res_valid,
    output mmp_pkg::result_t               res
);

    logic [mmp_pkg::SEL_W-1:0]  port_select_reg;
    logic                       ready_flag_reg;
    logic                       ready_flag_next;
    mmp_pkg::kind_t             msg_kind_reg;
    mmp_pkg::kind_t             msg_kind_next;
    logic [mmp_pkg::CHAN_W-1:0] held_channel_reg;
    logic [mmp_pkg::CHAN_W-1:0] held_channel_next;
    logic [mmp_pkg::DATA_W-1:0] first_data_reg;
    logic [mmp_pkg::DATA_W-1:0] first_data_next;

    logic [mmp_pkg::SEL_W-1:0]  pnum;
    logic                       port_match;
    logic                       is_status;
    logic [3:0]                 status_hi;
    logic [3:0]                 status_lo;
    logic [mmp_pkg::DATA_W-1:0] data;
    logic                       produce;
    logic                       is_note;
    logic                       is_bend;

    assign pnum       = mmp_pkg::SEL_W'(item.port) + 1'b1;
    assign port_match = (port_select_reg == '0)
                     || ((int'(port_select_reg) <= mmp_pkg::PORT_COUNT)
                         && (port_select_reg == pnum));
    assign is_status  = item.midi_byte[7];
    assign status_hi  = item.midi_byte[7:4];
    assign status_lo  = item.midi_byte[3:0];
    assign data       = item.midi_byte[mmp_pkg::DATA_W-1:0];

    assign produce = port_match && !is_status && (msg_kind_reg != mmp_pkg::KIND_NONE)
                  && ready_flag_reg;

    // A byte that makes no result never waits for the output stage.
    assign consume   = ctrl.in_valid && (!produce || ctrl.out_free);
    assign res_valid = consume && produce;

    assign is_note = (msg_kind_reg == mmp_pkg::KIND_NOTE_ON)
                  || (msg_kind_reg == mmp_pkg::KIND_NOTE_OFF);
    assign is_bend = (msg_kind_reg == mmp_pkg::KIND_BEND);

    always_comb
    begin
        res.kind        = msg_kind_reg;
        res.channel     = held_channel_reg;
        res.key         = is_note ? first_data_reg : '0;
        res.amount      = is_bend ? '0 : data;
        res.bend_value  = is_bend ? {data, first_data_reg} : '0;
        res.port_number = pnum;
    end

    always_comb
    begin
        ready_flag_next   = ready_flag_reg;
        msg_kind_next     = msg_kind_reg;
        held_channel_next = held_channel_reg;
        first_data_next   = first_data_reg;
        if (port_match)
        begin
            if (is_status)
            begin
                ready_flag_next = 1'b0;
                msg_kind_next   = mmp_pkg::KIND_NONE;
                if (status_lo != 4'h0)
                begin
                    case (status_hi)
                        mmp_pkg::STATUS_NOTE_OFF: msg_kind_next = mmp_pkg::KIND_NOTE_OFF;
                        mmp_pkg::STATUS_NOTE_ON:  msg_kind_next = mmp_pkg::KIND_NOTE_ON;
                        mmp_pkg::STATUS_CC:       msg_kind_next = mmp_pkg::KIND_SLIDE;
                        mmp_pkg::STATUS_PRESSURE:
                        begin
                            msg_kind_next   = mmp_pkg::KIND_PRESSURE;
                            ready_flag_next = 1'b1;
                        end
                        mmp_pkg::STATUS_BEND:     msg_kind_next = mmp_pkg::KIND_BEND;
                        default:                  msg_kind_next = mmp_pkg::KIND_NONE;
                    endcase
                    if (msg_kind_next != mmp_pkg::KIND_NONE)
                    begin
                        held_channel_next = status_lo - 1'b1;
                    end
                end
            end
            else if (msg_kind_reg != mmp_pkg::KIND_NONE)
            begin
                if (ready_flag_reg)
                begin
                    ready_flag_next = 1'b0;
                    msg_kind_next   = mmp_pkg::KIND_NONE;
                end
                else if (msg_kind_reg == mmp_pkg::KIND_SLIDE)
                begin
                    // Other controller numbers are skipped; keep looking.
                    if (data == mmp_pkg::SLIDE_CC)
                    begin
                        ready_flag_next = 1'b1;
                    end
                end
                else
                begin
                    first_data_next = data;
                    ready_flag_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_select_reg  <= '0;
            ready_flag_reg   <= 1'b0;
            msg_kind_reg     <= mmp_pkg::KIND_NONE;
            held_channel_reg <= '0;
            first_data_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                port_select_reg <= cfg_wdata;
            end
            if (consume)
            begin
                ready_flag_reg   <= ready_flag_next;
                msg_kind_reg     <= msg_kind_next;
                held_channel_reg <= held_channel_next;
                first_data_reg   <= first_data_next;
            end
        end
    end

    // A pending completion always has a message behind it.
    a_ready_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
        ready_flag_reg |-> (msg_kind_reg != mmp_pkg::KIND_NONE))
        else $error("ready flag set with no message pending");

    // Emitting a result returns the parser to idle.
    a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> ((msg_kind_reg == mmp_pkg::KIND_NONE) && !ready_flag_reg))
        else $error("parser not idle after a result");

    // A result is never issued while the output stage is full.
    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ctrl.out_free)
        else $error("result issued with no room downstream");

endmodule

// File: hw/rtl/mmp_out_reg.sv
// ----------------------------------------------------------------------------
// MPE MIDI output register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module mmp_out_reg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 res_valid,
    input  mmp_pkg::result_t                     res,
    output logic                                 out_free,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mmp_pkg::TDATA_OUT_W-1:0]      m_tdata,
    output logic [mmp_pkg::TUSER_OUT_W-1:0]      m_tuser
);

    logic             valid_reg;
    logic             valid_next;
    mmp_pkg::result_t res_reg;

    assign out_free   = !valid_reg || m_tready;
    assign valid_next = res_valid ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {3'b000, res_reg.port_number, res_reg.bend_value,
                       res_reg.amount, res_reg.key, res_reg.channel};

endmodule

// File: sim/mpe_midi_message_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MPE MIDI message parser testbench
// Drives tagged MIDI bytes into the parser with random flow control on both
// streams. A local decoder predicts every voice message and a monitor checks
// each result word field by field. The port selector is swept between phases.
// ----------------------------------------------------------------------------
module mpe_midi_message_parser_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTS  = 100;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [mmp_pkg::TDATA_IN_W-1:0]  s_tdata;   // midi_byte[7:0]
    logic [mmp_pkg::TUSER_IN_W-1:0]  s_tuser;   // port[3:0]
    logic                            m_tvalid;
    logic                            m_tready;
    // channel, key, amount, bend_value, port_number
    logic [mmp_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic [mmp_pkg::TUSER_OUT_W-1:0] m_tuser;   // kind[2:0]
    logic                            cfg_we;
    logic [mmp_pkg::SEL_W-1:0]       cfg_wdata;

    // Local copy of the parser state and the port selector.
    mmp_pkg::kind_t             pend_kind = mmp_pkg::KIND_NONE;
    logic                       pend_ready = 1'b0;
    logic [mmp_pkg::CHAN_W-1:0] pend_chan = '0;
    logic [mmp_pkg::DATA_W-1:0] first_data = '0;
    logic [mmp_pkg::SEL_W-1:0]  port_select_q = '0;

    mmp_pkg::result_t decoded_msgs[$];
    mmp_pkg::result_t want;
    int      errors = 0;
    int      sent_words = 0;
    int      cycle_count = 0;
    logic    no_gaps = 1'b0;

    mpe_midi_message_parser u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** mpe_midi_message_parser: FAILED **");
            $finish;
        end
    end

    // The receiver stalls at random unless a no-gap stretch is running.
    always @(negedge clk)
        m_tready = no_gaps || ($urandom_range(99) >= 32);

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t ERROR %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int exp_v);
        if (got != exp_v)
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, exp_v));
    endtask

    // Works out what one accepted byte does to the parser state and pushes
    // the completed message, if any.
    function automatic void decode_byte(input logic [7:0] b, input logic [3:0] p);
        logic [mmp_pkg::SEL_W-1:0] pnum;
        mmp_pkg::result_t          r;
        pnum = {1'b0, p} + 5'd1;
        if (port_select_q != '0
            && (port_select_q > mmp_pkg::PORT_COUNT || port_select_q != pnum))
            return;
        if (b[7])
        begin
            pend_ready = 1'b0;
            pend_kind  = mmp_pkg::KIND_NONE;
            if (b[3:0] == 4'd0)
                return;
            case (b[7:4])
                mmp_pkg::STATUS_NOTE_OFF: pend_kind = mmp_pkg::KIND_NOTE_OFF;
                mmp_pkg::STATUS_NOTE_ON:  pend_kind = mmp_pkg::KIND_NOTE_ON;
                mmp_pkg::STATUS_CC:       pend_kind = mmp_pkg::KIND_SLIDE;
                mmp_pkg::STATUS_PRESSURE:
                begin
                    pend_kind  = mmp_pkg::KIND_PRESSURE;
                    pend_ready = 1'b1;
                end
                mmp_pkg::STATUS_BEND:     pend_kind = mmp_pkg::KIND_BEND;
                default:                  pend_kind = mmp_pkg::KIND_NONE;
            endcase
            if (pend_kind != mmp_pkg::KIND_NONE)
                pend_chan = b[3:0] - 4'd1;
            return;
        end
        if (pend_kind == mmp_pkg::KIND_NONE)
            return;
        if (!pend_ready)
        begin
            // A controller other than slide is skipped; the next byte is
            // tested again as a controller number.
            if (pend_kind == mmp_pkg::KIND_SLIDE)
            begin
                if (b[6:0] == mmp_pkg::SLIDE_CC)
                    pend_ready = 1'b1;
            end
            else
            begin
                first_data = b[6:0];
                pend_ready = 1'b1;
            end
            return;
        end
        r.kind        = pend_kind;
        r.channel     = pend_chan;
        r.key         = (pend_kind == mmp_pkg::KIND_NOTE_ON
                         || pend_kind == mmp_pkg::KIND_NOTE_OFF) ? first_data : '0;
        r.amount      = (pend_kind == mmp_pkg::KIND_BEND) ? '0 : b[6:0];
        r.bend_value  = (pend_kind == mmp_pkg::KIND_BEND) ? {b[6:0], first_data} : '0;
        r.port_number = pnum;
        decoded_msgs.push_back(r);
        pend_ready = 1'b0;
        pend_kind  = mmp_pkg::KIND_NONE;
    endfunction

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (decoded_msgs.size() == 0)
                report_mismatch($sformatf("unexpected result: tuser=%0d tdata=%h",
                                          m_tuser, m_tdata));
            else
            begin
                want = decoded_msgs.pop_front();
                check_field("kind", int'(m_tuser), int'(want.kind));
                check_field("channel", int'(m_tdata[3:0]), int'(want.channel));
                check_field("key", int'(m_tdata[10:4]), int'(want.key));
                check_field("amount", int'(m_tdata[17:11]), int'(want.amount));
                check_field("bend_value", int'(m_tdata[31:18]), int'(want.bend_value));
                check_field("port_number", int'(m_tdata[36:32]),
                            int'(want.port_number));
            end
        end
    end

    // Sends one word, with random idle cycles ahead of it, and returns once
    // it has been accepted.
    task automatic send_word(input logic [7:0] b, input logic [3:0] p);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < 32)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = p;
        do
            @(posedge clk);
        while (!s_tready);
        decode_byte(b, p);
        sent_words++;
    endtask

    // Stops sending and waits until every pending result has come out. A final
    // wait lets bytes that complete no message clear the pipe.
    task automatic wait_drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (decoded_msgs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_port_select(input logic [mmp_pkg::SEL_W-1:0] v);
        wait_drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        port_select_q = v;
    endtask

    function automatic logic [3:0] pick_port();
        if (port_select_q != '0 && port_select_q <= mmp_pkg::PORT_COUNT
            && $urandom_range(99) < 75)
            return 4'(port_select_q - 5'd1);
        return 4'($urandom_range(15));
    endfunction

    function automatic logic [7:0] rand_data();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'h7F;
            default: return 8'($urandom_range(127));
        endcase
    endfunction

    // Mostly well-formed messages with random content; some are cut short,
    // broken by a realtime byte, or replaced by a random byte.
    task automatic send_random_message();
        int         r;
        int         n_data;
        logic [3:0] hi;
        logic [3:0] ch;
        logic [3:0] p;
        r = $urandom_range(99);
        p = pick_port();
        if (r < 8)
        begin
            send_word(8'($urandom_range(255)), p);
            return;
        end
        case ($urandom_range(4))
            0:       hi = mmp_pkg::STATUS_NOTE_ON;
            1:       hi = mmp_pkg::STATUS_NOTE_OFF;
            2:       hi = mmp_pkg::STATUS_CC;
            3:       hi = mmp_pkg::STATUS_PRESSURE;
            default: hi = mmp_pkg::STATUS_BEND;
        endcase
        ch = (r < 12) ? 4'd0 : 4'($urandom_range(1, 15));
        send_word({hi, ch}, p);
        n_data = (hi == mmp_pkg::STATUS_PRESSURE) ? 1 : 2;
        if (hi == mmp_pkg::STATUS_CC)
        begin
            repeat ($urandom_range(0, 2))
                send_word(8'($urandom_range(127)), p);
            if ($urandom_range(9) != 0)
                send_word({1'b0, mmp_pkg::SLIDE_CC}, p);
            n_data = 1;
        end
        if ($urandom_range(99) < 8)
            n_data--;
        repeat (n_data)
        begin
            if ($urandom_range(99) < 4)
                send_word(8'($urandom_range(8'hF8, 8'hFF)), p);
            send_word(rand_data(), p);
        end
    endtask

    // Note on at both extremes, the other kinds, a skipped controller, velocity
    // zero, and the bytes that cancel or get ignored.
    task automatic test_directed();
        logic [7:0] seq [26] = '{
            8'h91, 8'h00, 8'h00,
            8'h9F, 8'h7F, 8'h7F,
            8'h81, 8'h3C, 8'h40,
            8'hD5, 8'h7F,
            8'hB3, 8'h07, 8'h4A, 8'h55,
            8'hEF, 8'h7F, 8'h7F,
            8'h90, 8'h40,
            8'h95, 8'h40, 8'hF8, 8'h40,
            8'hA1, 8'h10
        };
        for (int i = 0; i < 26; i++)
            send_word(seq[i], (i < 13) ? 4'd0 : 4'd15);
        wait_drain();
    endtask

    task automatic test_port_select();
        logic [mmp_pkg::SEL_W-1:0] sels [4] = '{5'd16, 5'd1, 5'd31, 5'd17};
        for (int i = 0; i < 4; i++)
        begin
            write_port_select(sels[i]);
            repeat (20)
                send_random_message();
        end
        write_port_select(5'd0);
    endtask

    task automatic test_random_traffic();
        int target;
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph == 1 || ph == 3)
                write_port_select(5'($urandom_range(1, mmp_pkg::PORT_COUNT)));
            else
                write_port_select(5'd0);
            no_gaps = (ph == 2);
            target = sent_words + 180;
            while (sent_words < target)
            begin
                send_random_message();
                // Hold the sender off now and then until the output is empty.
                if ($urandom_range(99) < 2)
                    wait_drain();
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_port_select();
        test_random_traffic();

        wait_drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("** mpe_midi_message_parser: PASSED **");
        else
            $display("** mpe_midi_message_parser: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/mmp_pkg.sv
hw/rtl/mmp_in_reg.sv
hw/rtl/mmp_decode.sv
hw/rtl/mmp_out_reg.sv
hw/rtl/mpe_midi_message_parser.sv
sim/mpe_midi_message_parser_tb.sv
